@@ hdl/tce_pkg.sv @@
// Shared types and constants for the task cost estimator.
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;
    localparam int WORK_W = 48;
    localparam int RATE_W = 16;
    localparam int LAT_W  = 49;
    localparam int RD_W   = 36;
    localparam int WR_W   = 35;
    localparam int CELLS  = WORK_W;

    typedef enum logic [1:0] {
        KIND_DMA     = 2'd0,
        KIND_MATMUL  = 2'd1,
        KIND_VECTOR  = 2'd2,
        KIND_RESHAPE = 2'd3
    } t_kind;

    localparam logic [2:0] REG_OVERHEAD = 3'd0;
    localparam logic [2:0] REG_DMA      = 3'd1;
    localparam logic [2:0] REG_MATMUL   = 3'd2;
    localparam logic [2:0] REG_VECTOR   = 3'd3;
    localparam logic [2:0] REG_RESHAPE  = 3'd4;

    typedef struct packed {
        logic [RD_W-1:0] rd;
        logic [WR_W-1:0] wr;
        logic            err;
    } t_side;

    // one divider beat: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [RATE_W-1:0] rem;
        logic [WORK_W-1:0] nq;
        logic [RATE_W-1:0] div;
        t_side             side;
    } t_cell;
endpackage
`default_nettype wire

@@ hdl/tce_front.sv @@
// Front end: products, workload select and SRAM byte counts.
`timescale 1ns / 1ps
`default_nettype none
module tce_front import tce_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  wire  [1:0]        i_task_kind,
    input  wire  [31:0]       i_byte_count,
    input  wire  [15:0]       i_dim_m,
    input  wire  [15:0]       i_dim_n,
    input  wire  [15:0]       i_dim_k,
    input  wire  [31:0]       i_element_count,
    input  wire  [3:0]        i_elem_type,
    input  wire               i_dma_dir,
    input  wire  [RATE_W-1:0] i_dma_rate,
    input  wire  [RATE_W-1:0] i_matmul_rate,
    input  wire  [RATE_W-1:0] i_vector_rate,
    input  wire  [RATE_W-1:0] i_reshape_rate,
    output logic              o_valid,
    output t_cell             o_beat
);
    logic              r_a_valid;
    logic [31:0]       r_mn, r_mk, r_kn;
    logic [15:0]       r_k;
    t_kind             r_kind;
    logic [31:0]       r_bytes, r_cnt;
    logic [3:0]        r_code;
    logic              r_dir;
    logic [RATE_W-1:0] r_div;
    logic [RATE_W-1:0] n_div;
    logic              r_b_valid;
    t_cell             r_beat;
    t_cell             n_beat;

    always_comb begin
        case (t_kind'(i_task_kind))
            KIND_DMA:    n_div = i_dma_rate;
            KIND_MATMUL: n_div = i_matmul_rate;
            KIND_VECTOR: n_div = i_vector_rate;
            default:     n_div = i_reshape_rate;
        endcase
        if (n_div == '0) n_div = RATE_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_mn    <= i_dim_m * i_dim_n;
            r_mk    <= i_dim_m * i_dim_k;
            r_kn    <= i_dim_k * i_dim_n;
            r_k     <= i_dim_k;
            r_kind  <= t_kind'(i_task_kind);
            r_bytes <= i_byte_count;
            r_cnt   <= i_element_count;
            r_code  <= i_elem_type;
            r_dir   <= i_dma_dir;
            r_div   <= n_div;
            r_beat  <= n_beat;
        end
    end

    logic       bad;
    logic [1:0] sh;
    logic [32:0] mk_kn;
    logic [WORK_W-1:0] mnk;
    always_comb begin
        bad   = (r_code[3:2] != 2'b00);
        sh    = r_code[1:0];
        mk_kn = {1'b0, r_mk} + {1'b0, r_kn};
        mnk   = r_mn * r_k;
        n_beat          = '0;
        n_beat.div      = r_div;
        case (r_kind)
            KIND_DMA: begin
                n_beat.nq      = WORK_W'(r_bytes);
                n_beat.side.rd = r_dir ? RD_W'(r_bytes) : '0;
                n_beat.side.wr = r_dir ? '0 : WR_W'(r_bytes);
            end
            KIND_MATMUL: begin
                n_beat.nq = mnk;
                if (bad) begin
                    n_beat.side.err = 1'b1;
                end else begin
                    n_beat.side.rd = RD_W'(mk_kn) << sh;
                    n_beat.side.wr = WR_W'(r_mn) << sh;
                end
            end
            KIND_VECTOR: begin
                n_beat.nq = WORK_W'(r_cnt);
                if (bad) begin
                    n_beat.side.err = 1'b1;
                end else begin
                    n_beat.side.rd = RD_W'({r_cnt, 1'b0}) << sh;
                    n_beat.side.wr = WR_W'(r_cnt) << sh;
                end
            end
            default: begin
                n_beat.nq      = WORK_W'(r_cnt);
                n_beat.side.rd = RD_W'(r_cnt);
                n_beat.side.wr = WR_W'(r_cnt);
            end
        endcase
    end

    assign o_valid = r_b_valid;
    assign o_beat  = r_beat;
endmodule
`default_nettype wire

@@ hdl/tce_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per beat.
`timescale 1ns / 1ps
`default_nettype none
module tce_div_cell import tce_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_cell i_beat,
    output logic  o_valid,
    output t_cell o_beat
);
    logic            r_valid;
    t_cell           r_beat;
    t_cell           n_beat;
    logic [RATE_W:0] trial;
    logic            ge;

    always_comb begin
        trial     = {i_beat.rem, i_beat.nq[WORK_W-1]};
        ge        = (trial >= {1'b0, i_beat.div});
        n_beat    = i_beat;
        n_beat.rem = ge ? RATE_W'(trial - {1'b0, i_beat.div}) : RATE_W'(trial);
        n_beat.nq  = {i_beat.nq[WORK_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
endmodule
`default_nettype wire

@@ hdl/task_cost_estimator.sv @@
// Task cost estimator top level: config registers, divider chain, output stage.
// Usage:
//  Input channel i_valid/o_stall carries one task descriptor per beat; output
//  channel o_valid/i_stall carries latency, SRAM read/write bytes and type error.
//  Configuration is a write port (i_cfg_we, i_cfg_index, i_cfg_data); write only
//  while no task is in flight. Unknown indexes are ignored.
//  Pipeline from input beat to output valid: two front stages
//  (products, workload select), 48 division cells resolving one quotient bit
//  each, and the output register with overhead add and clamp.
//  Throughput: one task per cycle when not stalled; 48 division cells set the depth.
//  When the receiver stalls a held result, the whole pipeline freezes and
//  o_stall rises; it falls as soon as the output beat is taken.
//  Reset clears all valid flags and loads the default rates (overhead 0,
//  DMA 64, matmul 1024, vector 32, reshape 32).
//  A zero rate is treated as a rate of one.
`timescale 1ns / 1ps
`default_nettype none
module task_cost_estimator import tce_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire  [1:0]        i_task_kind,
    input  wire  [31:0]       i_byte_count,
    input  wire  [15:0]       i_dim_m,
    input  wire  [15:0]       i_dim_n,
    input  wire  [15:0]       i_dim_k,
    input  wire  [31:0]       i_element_count,
    input  wire  [3:0]        i_elem_type,
    input  wire               i_dma_dir,
    input  wire               i_cfg_we,
    input  wire  [2:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [LAT_W-1:0]  o_latency_cycles,
    output logic [RD_W-1:0]   o_sram_read_bytes,
    output logic [WR_W-1:0]   o_sram_write_bytes,
    output logic              o_type_error
);
    logic [15:0]       r_overhead;
    logic [RATE_W-1:0] r_dma_rate, r_matmul_rate, r_vector_rate, r_reshape_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overhead     <= '0;
            r_dma_rate     <= RATE_W'(64);
            r_matmul_rate  <= RATE_W'(1024);
            r_vector_rate  <= RATE_W'(32);
            r_reshape_rate <= RATE_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OVERHEAD: r_overhead     <= i_cfg_data;
                REG_DMA:      r_dma_rate     <= i_cfg_data;
                REG_MATMUL:   r_matmul_rate  <= i_cfg_data;
                REG_VECTOR:   r_vector_rate  <= i_cfg_data;
                REG_RESHAPE:  r_reshape_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic en;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    logic  v_chain [CELLS+1];
    t_cell b_chain [CELLS+1];

    tce_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_valid),
        .i_task_kind     (i_task_kind),
        .i_byte_count    (i_byte_count),
        .i_dim_m         (i_dim_m),
        .i_dim_n         (i_dim_n),
        .i_dim_k         (i_dim_k),
        .i_element_count (i_element_count),
        .i_elem_type     (i_elem_type),
        .i_dma_dir       (i_dma_dir),
        .i_dma_rate      (r_dma_rate),
        .i_matmul_rate   (r_matmul_rate),
        .i_vector_rate   (r_vector_rate),
        .i_reshape_rate  (r_reshape_rate),
        .o_valid         (v_chain[0]),
        .o_beat          (b_chain[0])
    );

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        tce_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[g]),
            .i_beat  (b_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_beat  (b_chain[g+1])
        );
    end

    // ceil = floor + (remainder != 0); then signed overhead and clamp to 1
    t_cell              tail;
    logic [WORK_W-1:0]  work;
    logic signed [LAT_W:0] sum;
    logic [LAT_W-1:0]   n_lat;
    always_comb begin
        tail  = b_chain[CELLS];
        work  = tail.nq + WORK_W'(tail.rem != '0);
        sum   = $signed({2'b00, work}) + $signed({{(LAT_W-15){r_overhead[15]}}, r_overhead});
        n_lat = (sum < $signed((LAT_W+1)'(1))) ? LAT_W'(1) : sum[LAT_W-1:0];
    end

    logic [LAT_W-1:0] r_lat;
    t_side            r_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_chain[CELLS];
        end
        if (en) begin
            r_lat  <= n_lat;
            r_side <= tail.side;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_latency_cycles   = r_lat;
    assign o_sram_read_bytes  = r_side.rd;
    assign o_sram_write_bytes = r_side.wr;
    assign o_type_error       = r_side.err;

    a_lat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_latency_cycles != '0))
        else $error("latency below one");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_type_error) |->
            (o_sram_read_bytes == '0 && o_sram_write_bytes == '0))
        else $error("type error with nonzero byte counts");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_latency_cycles) && $stable(o_sram_read_bytes)))
        else $error("output beat changed under stall");
endmodule
`default_nettype wire

@@ sim/tce_checker.sv @@
// Checker for the task cost estimator: predicts each result and compares output beats.
`timescale 1ns / 1ps
module tce_checker import tce_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire              i_in_stall,
    input  wire [1:0]        i_task_kind,
    input  wire [31:0]       i_byte_count,
    input  wire [15:0]       i_dim_m,
    input  wire [15:0]       i_dim_n,
    input  wire [15:0]       i_dim_k,
    input  wire [31:0]       i_element_count,
    input  wire [3:0]        i_elem_type,
    input  wire              i_dma_dir,
    input  wire              i_cfg_we,
    input  wire [2:0]        i_cfg_index,
    input  wire [15:0]       i_cfg_data,
    input  wire              i_out_valid,
    input  wire              i_out_stall,
    input  wire [LAT_W-1:0]  i_latency_cycles,
    input  wire [RD_W-1:0]   i_sram_read_bytes,
    input  wire [WR_W-1:0]   i_sram_write_bytes,
    input  wire              i_type_error,
    output int               o_pending,
    output int               o_errors
);
    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [RD_W-1:0]  rd;
        logic [WR_W-1:0]  wr;
        logic             err;
    } t_cost;

    logic signed [15:0] overhead;
    logic [15:0] rate_dma, rate_mm, rate_vec, rate_rsh;
    t_cost cost_q[$];
    int errors = 0;

    assign o_pending = cost_q.size();
    assign o_errors  = errors;

    function automatic logic [63:0] div_up(logic [63:0] work, logic [15:0] rate);
        logic [63:0] d;
        d = (rate == 16'd0) ? 64'd1 : 64'(rate);
        return (work + d - 64'd1) / d;
    endfunction

    function automatic t_cost estimate(t_kind kind, logic [31:0] bytes, logic [15:0] m,
                                       logic [15:0] n, logic [15:0] k, logic [31:0] cnt,
                                       logic [3:0] code, logic dir);
        t_cost c;
        logic [63:0] work, size, rd, wr;
        logic bad;
        longint lat;
        bad  = code > 4'd3;
        size = bad ? 64'd0 : (64'd1 << code);
        rd = 0;
        wr = 0;
        c.err = 1'b0;
        case (kind)
            KIND_DMA: begin
                work = div_up(64'(bytes), rate_dma);
                rd = dir ? 64'(bytes) : 64'd0;
                wr = dir ? 64'd0 : 64'(bytes);
            end
            KIND_MATMUL: begin
                work = div_up(64'(m) * 64'(n) * 64'(k), rate_mm);
                if (bad) begin
                    c.err = 1'b1;
                end else begin
                    rd = (64'(m) * 64'(k) + 64'(k) * 64'(n)) * size;
                    wr = 64'(m) * 64'(n) * size;
                end
            end
            KIND_VECTOR: begin
                work = div_up(64'(cnt), rate_vec);
                if (bad) begin
                    c.err = 1'b1;
                end else begin
                    rd = 64'd2 * 64'(cnt) * size;
                    wr = 64'(cnt) * size;
                end
            end
            default: begin
                work = div_up(64'(cnt), rate_rsh);
                rd = 64'(cnt);
                wr = 64'(cnt);
            end
        endcase
        lat = longint'(work) + longint'(overhead);
        if (lat < 1) lat = 1;
        c.lat = lat[LAT_W-1:0];
        c.rd  = rd[RD_W-1:0];
        c.wr  = wr[WR_W-1:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_cost want;
        if (!i_rst_n) begin
            overhead <= 16'sd0;
            rate_dma <= 16'd64;
            rate_mm  <= 16'd1024;
            rate_vec <= 16'd32;
            rate_rsh <= 16'd32;
            cost_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OVERHEAD: overhead <= i_cfg_data;
                    REG_DMA:      rate_dma <= i_cfg_data;
                    REG_MATMUL:   rate_mm  <= i_cfg_data;
                    REG_VECTOR:   rate_vec <= i_cfg_data;
                    REG_RESHAPE:  rate_rsh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                cost_q.push_back(estimate(t_kind'(i_task_kind), i_byte_count, i_dim_m,
                                          i_dim_n, i_dim_k, i_element_count,
                                          i_elem_type, i_dma_dir));
            if (i_out_valid && !i_out_stall) begin
                if (cost_q.size() == 0) begin
                    $error("output beat with no pending task");
                    errors++;
                end else begin
                    want = cost_q.pop_front();
                    if (i_latency_cycles !== want.lat) begin
                        $error("latency_cycles: expected %0d, got %0d", want.lat,
                               i_latency_cycles);
                        errors++;
                    end
                    if (i_sram_read_bytes !== want.rd) begin
                        $error("sram_read_bytes: expected %0d, got %0d", want.rd,
                               i_sram_read_bytes);
                        errors++;
                    end
                    if (i_sram_write_bytes !== want.wr) begin
                        $error("sram_write_bytes: expected %0d, got %0d", want.wr,
                               i_sram_write_bytes);
                        errors++;
                    end
                    if (i_type_error !== want.err) begin
                        $error("type_error: expected %0d, got %0d", want.err, i_type_error);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

@@ sim/tb.sv @@
// Testbench top for the task cost estimator: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb;
    import tce_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int DRAIN = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_task_kind = '0;
    logic [31:0] i_byte_count = '0;
    logic [15:0] i_dim_m = '0, i_dim_n = '0, i_dim_k = '0;
    logic [31:0] i_element_count = '0;
    logic [3:0] i_elem_type = '0;
    logic i_dma_dir = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [LAT_W-1:0] o_latency_cycles;
    logic [RD_W-1:0] o_sram_read_bytes;
    logic [WR_W-1:0] o_sram_write_bytes;
    logic o_type_error;
    int pending, errors;
    bit hold_out = 0;
    bit no_gaps = 0;

    always #4 i_clk = ~i_clk;

    task_cost_estimator dut (.*);

    tce_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_task_kind, .i_byte_count,
        .i_dim_m, .i_dim_n, .i_dim_k, .i_element_count, .i_elem_type, .i_dma_dir,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_latency_cycles(o_latency_cycles), .i_sram_read_bytes(o_sram_read_bytes),
        .i_sram_write_bytes(o_sram_write_bytes), .i_type_error(o_type_error),
        .o_pending(pending), .o_errors(errors)
    );

    function automatic int gap_len();
        if (no_gaps) return 0;
        return ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // receiver side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_out) begin
                i_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge i_clk);
                hold_out = 0;
            end else begin
                n = gap_len();
                i_stall <= (n != 0);
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_task(logic [1:0] kind, logic [31:0] bytes, logic [15:0] m,
                             logic [15:0] n, logic [15:0] k, logic [31:0] cnt,
                             logic [3:0] code, logic dir);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_task_kind <= kind;
        i_byte_count <= bytes;
        i_dim_m <= m;
        i_dim_n <= n;
        i_dim_k <= k;
        i_element_count <= cnt;
        i_elem_type <= code;
        i_dma_dir <= dir;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [15:0] ovh, logic [15:0] rd, logic [15:0] rm,
                             logic [15:0] rv, logic [15:0] rr);
        write_reg(REG_OVERHEAD, ovh);
        write_reg(REG_DMA, rd);
        write_reg(REG_MATMUL, rm);
        write_reg(REG_VECTOR, rv);
        write_reg(REG_RESHAPE, rr);
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'd0;
            3: return 16'($urandom_range(1, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 300));
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_task();
        logic [3:0] code;
        logic [31:0] cnt;
        code = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        cnt = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 5000)) : $urandom;
        send_task(2'($urandom), $urandom, pick_dim(), pick_dim(), pick_dim(), cnt, code,
                  1'($urandom));
    endtask

    initial begin
        int ph, i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: field extremes and every kind
        send_task(KIND_DMA, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 4'd0, 1'b0);
        send_task(KIND_DMA, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                  4'd15, 1'b1);
        send_task(KIND_DMA, 32'hFFFFFFFF, 16'd0, 16'd0, 16'd0, 32'd0, 4'd9, 1'b0);
        send_task(KIND_MATMUL, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 4'd3, 1'b0);
        send_task(KIND_MATMUL, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 4'd15, 1'b1);
        send_task(KIND_MATMUL, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 4'd4, 1'b0);
        send_task(KIND_VECTOR, 32'd0, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF, 4'd3, 1'b0);
        send_task(KIND_VECTOR, 32'd0, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF, 4'd4, 1'b0);
        send_task(KIND_VECTOR, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 4'd1, 1'b0);
        send_task(KIND_RESHAPE, 32'd0, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF, 4'd7, 1'b0);
        send_task(KIND_RESHAPE, 32'd0, 16'd0, 16'd0, 16'd0, 32'd1, 4'd2, 1'b1);
        drain();
        // most negative overhead forces the clamp; unit rates; ignored index
        write_all(16'h8000, 16'd1, 16'd1, 16'd1, 16'd1);
        write_reg(REG_UNUSED, 16'd7);
        send_task(KIND_DMA, 32'd100, 16'd0, 16'd0, 16'd0, 32'd0, 4'd0, 1'b1);
        send_task(KIND_MATMUL, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 4'd2, 1'b0);
        send_task(KIND_VECTOR, 32'd0, 16'd0, 16'd0, 16'd0, 32'd32768, 4'd0, 1'b0);
        send_task(KIND_RESHAPE, 32'd0, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF, 4'd0, 1'b0);
        drain();
        // largest overhead and rates, then zero rates
        write_all(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_task(KIND_DMA, 32'hFFFFFFFF, 16'd0, 16'd0, 16'd0, 32'd0, 4'd0, 1'b1);
        send_task(KIND_MATMUL, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 4'd1, 1'b0);
        send_task(KIND_RESHAPE, 32'd0, 16'd0, 16'd0, 16'd0, 32'd65536, 4'd0, 1'b0);
        drain();
        write_all(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_task(KIND_DMA, 32'd5, 16'd0, 16'd0, 16'd0, 32'd0, 4'd0, 1'b0);
        send_task(KIND_MATMUL, 32'd0, 16'd3, 16'd5, 16'd7, 32'd0, 4'd3, 1'b0);
        send_task(KIND_VECTOR, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 4'd0, 1'b0);
        send_task(KIND_RESHAPE, 32'd0, 16'd0, 16'd0, 16'd0, 32'd9, 4'd0, 1'b0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            write_all(($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom_range(0, 200) - 100),
                      pick_rate(), pick_rate(), pick_rate(), pick_rate());
            no_gaps = (ph == 2);
            for (i = 0; i < 320; i++) begin
                if (ph == 1 && i == 100) hold_out = 1;
                if (ph == 4 && i == 160) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                random_task();
            end
            drain();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("Verification failed");
        $finish;
    end
endmodule
